@@ rtl/core/modbus_rtu_reply_checker_assert.svh @@
// Assertion macros for the checker file.
`ifndef MODBUS_RTU_REPLY_CHECKER_ASSERT_SVH
`define MODBUS_RTU_REPLY_CHECKER_ASSERT_SVH

// Clocked check, quiet while reset is high.
`define MRRC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs through reset.
`define MRRC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/core/mrrc_pkg.sv @@
`timescale 1ns / 1ps
package mrrc_pkg;

   localparam int FRAME_BYTES = 16;
   localparam int MIN_FRAME   = 5;
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
   localparam int LEN_W       = 5;

   localparam logic [15:0] CRC_INIT     = 16'hFFFF;
   localparam logic [15:0] CRC_POLY     = 16'hA001;
   localparam logic [7:0]  FUNC_READ    = 8'h03;
   localparam logic [15:0] GAP_RESET    = 16'd305;
   localparam logic [31:0] TIMEOUT_RESET = 32'd500000;

   // Register indexes on the csr port
   localparam logic CSR_GAP_TICKS     = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_TIMEOUT = 3'd1,
      ST_SHORT   = 3'd2,
      ST_CRC     = 3'd3,
      ST_HEADER  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] slave_addr;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [31:0]      distance;
      logic [LEN_W-1:0] frame_len;
   } result_type;

   // One byte through the reflected Modbus CRC-16
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else      c = c >> 1;
      end
      return c;
   endfunction

   // Check a finished frame and build its result
   function automatic result_type frame_result(
      input logic [CNT_W-1:0] n,
      input logic [15:0]      crc,
      input logic [7:0]       held0,
      input logic [7:0]       held1,
      input logic             hdr_ok,
      input logic [7:0]       dcount,
      input logic [31:0]      vacc
   );
      result_type r;
      logic [7:0] got;
      logic [7:0] missing;
      r.frame_len = LEN_W'(n);
      r.distance  = '0;
      got         = 8'(n) - 8'd3;
      if (got > dcount) got = dcount;
      missing = dcount - got;
      if (n < CNT_W'(MIN_FRAME)) begin
         r.status = ST_SHORT;
      end else if (crc[7:0] != held0 || crc[15:8] != held1) begin
         r.status = ST_CRC;
      end else if (!hdr_ok) begin
         r.status = ST_HEADER;
      end else begin
         r.status = ST_OK;
         if (missing < 8'd4) r.distance = vacc << {missing[1:0], 3'b000};
      end
      return r;
   endfunction

endpackage

@@ rtl/core/mrrc_frame.sv @@
`timescale 1ns / 1ps
module mrrc_frame import mrrc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  item_type    item,
   input  logic [15:0] gap_ticks,
   input  logic [31:0] timeout_ticks,
   output logic        res_valid,
   output result_type  res
);

   logic             busy_ff, busy_in;
   logic [7:0]       addr_ff, addr_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       held0_ff, held0_in, held1_ff, held1_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic             hdr_ok_ff, hdr_ok_in;
   logic [7:0]       dcount_ff, dcount_in;
   logic [31:0]      vacc_ff, vacc_in;
   logic [15:0]      silence_ff, silence_in;
   logic [31:0]      wait_ff, wait_in;
   logic             gap_end, time_end;

   always_comb begin
      busy_in    = busy_ff;
      addr_in    = addr_ff;
      crc_in     = crc_ff;
      held0_in   = held0_ff;
      held1_in   = held1_ff;
      total_in   = total_ff;
      hdr_ok_in  = hdr_ok_ff;
      dcount_in  = dcount_ff;
      vacc_in    = vacc_ff;
      silence_in = silence_ff;
      wait_in    = wait_ff;
      res_valid  = 1'b0;
      res        = '0;
      gap_end    = (total_ff != '0) && (silence_ff >= gap_ticks);
      time_end   = ({1'b0, wait_ff} + 33'd1) >= {1'b0, timeout_ticks};
      if (fire) begin
         case (cmd_type'(item.cmd))
            CMD_START: begin
               busy_in    = 1'b1;
               addr_in    = item.slave_addr;
               crc_in     = CRC_INIT;
               held0_in   = '0;
               held1_in   = '0;
               total_in   = '0;
               hdr_ok_in  = 1'b1;
               dcount_in  = '0;
               vacc_in    = '0;
               silence_in = '0;
               wait_in    = '0;
            end
            CMD_BYTE: begin
               if (busy_ff && total_ff < CNT_W'(FRAME_BYTES)) begin
                  if (total_ff == CNT_W'(0) && item.rx_byte != addr_ff) hdr_ok_in = 1'b0;
                  if (total_ff == CNT_W'(1) && item.rx_byte != FUNC_READ) hdr_ok_in = 1'b0;
                  if (total_ff == CNT_W'(2)) dcount_in = item.rx_byte;
                  if (total_ff >= CNT_W'(3) && (8'(total_ff) - 8'd3) < dcount_ff)
                     vacc_in = {vacc_ff[23:0], item.rx_byte};
                  if (total_ff >= CNT_W'(2)) crc_in = crc_feed(crc_ff, held0_ff);
                  held0_in   = held1_ff;
                  held1_in   = item.rx_byte;
                  total_in   = total_ff + CNT_W'(1);
                  silence_in = '0;
                  if (total_in == CNT_W'(FRAME_BYTES)) begin
                     res_valid = 1'b1;
                     res = frame_result(total_in, crc_in, held0_in, held1_in,
                                        hdr_ok_in, dcount_in, vacc_in);
                     busy_in = 1'b0;
                  end
               end
            end
            CMD_TICK: begin
               if (busy_ff) begin
                  if (silence_ff != 16'hFFFF) silence_in = silence_ff + 16'd1;
                  if (wait_ff != 32'hFFFF_FFFF) wait_in = wait_ff + 32'd1;
                  if (gap_end) begin
                     res_valid = 1'b1;
                     res = frame_result(total_ff, crc_ff, held0_ff, held1_ff,
                                        hdr_ok_ff, dcount_ff, vacc_ff);
                     busy_in = 1'b0;
                  end else if (time_end) begin
                     res_valid     = 1'b1;
                     res.status    = ST_TIMEOUT;
                     res.frame_len = LEN_W'(total_ff);
                     busy_in       = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         addr_ff    <= '0;
         crc_ff     <= CRC_INIT;
         held0_ff   <= '0;
         held1_ff   <= '0;
         total_ff   <= '0;
         hdr_ok_ff  <= 1'b1;
         dcount_ff  <= '0;
         vacc_ff    <= '0;
         silence_ff <= '0;
         wait_ff    <= '0;
      end else begin
         busy_ff    <= busy_in;
         addr_ff    <= addr_in;
         crc_ff     <= crc_in;
         held0_ff   <= held0_in;
         held1_ff   <= held1_in;
         total_ff   <= total_in;
         hdr_ok_ff  <= hdr_ok_in;
         dcount_ff  <= dcount_in;
         vacc_ff    <= vacc_in;
         silence_ff <= silence_in;
         wait_ff    <= wait_in;
      end
   end

endmodule

@@ rtl/core/mrrc_rsp_reg.sv @@
`timescale 1ns / 1ps
module mrrc_rsp_reg import mrrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  result_type       res,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_distance,
   output logic [LEN_W-1:0] rsp_frame_len
);

   logic       valid_ff;
   result_type res_ff;

   // Loads only come when the slot is empty or draining this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) res_ff <= res;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_status    = res_ff.status;
   assign rsp_distance  = res_ff.distance;
   assign rsp_frame_len = res_ff.frame_len;

endmodule

@@ rtl/core/modbus_rtu_reply_checker.sv @@
// Path: request register, frame logic, then result register, whose output is rsp_valid.
// Throughput: one request per cycle; the request register stalls only while
// a result is held and rsp_stall is high.
// Reset (synchronous, active high): idle, no result pending, gap_ticks 305,
// timeout_ticks 500000, frame state cleared.
`timescale 1ns / 1ps
module modbus_rtu_reply_checker import mrrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_cmd,
   input  logic [7:0]       req_slave_addr,
   input  logic [7:0]       req_rx_byte,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_distance,
   output logic [LEN_W-1:0] rsp_frame_len,
   // configuration writes
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [31:0]      csr_wr_data
);

   logic        in_valid_ff;
   item_type    item_ff;
   logic        advance;
   logic        fire;
   logic [15:0] gap_ticks_ff;
   logic [31:0] timeout_ticks_ff;
   logic        res_valid;
   result_type  res;

   // The frame stage may move on unless a finished result is held and stalled;
   // a request that gives no result is held back too, which keeps it simple.
   assign advance   = !(rsp_valid && rsp_stall);
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // Request register: refill whenever it is empty or being consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff.cmd        <= req_cmd;
         item_ff.slave_addr <= req_slave_addr;
         item_ff.rx_byte    <= req_rx_byte;
      end
   end

   // Configuration registers; the user must write them only while the block is idle (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff     <= GAP_RESET;
         timeout_ticks_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GAP_TICKS:     gap_ticks_ff     <= csr_wr_data[15:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Frame assembly, CRC and header checks, value collection
   mrrc_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .item          (item_ff),
      .gap_ticks     (gap_ticks_ff),
      .timeout_ticks (timeout_ticks_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   // Result register; holds the result while rsp_stall is high
   mrrc_rsp_reg u_rsp (
      .clock         (clock),
      .reset         (reset),
      .load          (res_valid),
      .res           (res),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_distance  (rsp_distance),
      .rsp_frame_len (rsp_frame_len)
   );

endmodule

@@ rtl/core/mrrc_checker.sv @@
`timescale 1ns / 1ps
`include "modbus_rtu_reply_checker_assert.svh"
module mrrc_checker import mrrc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [2:0]       rsp_status,
   input logic [31:0]      rsp_distance,
   input logic [LEN_W-1:0] rsp_frame_len
);

   logic rsp_held;
   logic rsp_fail;
   logic len_ok;

   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_fail = rsp_valid && (rsp_status != ST_OK);
   assign len_ok   = rsp_frame_len <= LEN_W'(FRAME_BYTES);

   `MRRC_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_valid, "result after reset")
   `MRRC_ASSERT(a_rsp_held, rsp_held |=> rsp_valid && $stable(rsp_distance), "stalled result lost")
   `MRRC_ASSERT(a_zero_on_fail, rsp_fail |-> rsp_distance == '0, "value with a failing status")
   `MRRC_ASSERT(a_len_bound, rsp_valid |-> len_ok, "frame length beyond the buffer")

endmodule

bind modbus_rtu_reply_checker mrrc_checker u_mrrc_checker (.*);

@@ tb/sv/tb_modbus_rtu_reply_checker.sv @@
`timescale 1ns / 1ps
module tb_modbus_rtu_reply_checker;
   import mrrc_pkg::*;

   // cmd 3 has no meaning; the checker must drop it
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int RANDOM_REQUESTS   = 950;
   localparam int CALM_FROM         = 750;
   localparam int PHASE_REQUESTS    = 160;
   localparam int REPORT_CAP        = 40;

   typedef struct {
      status_type       status;
      logic [31:0]      distance;
      logic [LEN_W-1:0] frame_len;
   } reply_fields;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_cmd = CMD_TICK;
   logic [7:0]       req_slave_addr = 8'h00;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [2:0]       rsp_status;
   logic [31:0]      rsp_distance;
   logic [LEN_W-1:0] rsp_frame_len;
   logic             csr_wr_en = 1'b0;
   logic             csr_index = CSR_GAP_TICKS;
   logic [31:0]      csr_wr_data = '0;

   // Our own copy of the frame tracker, advanced once per accepted request
   logic        frame_open;
   logic [7:0]  armed_addr;
   logic [15:0] crc_run;
   logic [7:0]  tail_bytes [2];
   int unsigned bytes_in;
   logic        header_good;
   logic [7:0]  data_len;
   logic [31:0] data_acc;
   logic [15:0] quiet_ticks;
   logic [31:0] waited_ticks;
   logic [15:0] gap_limit;
   logic [31:0] timeout_limit;

   reply_fields awaited_replies[$];
   logic [7:0]  frame_bytes[$];
   int          live_requests = 0;
   int          mismatch_count = 0;
   bit          idling_on = 1'b0;
   int          stall_left = 0;

   modbus_rtu_reply_checker i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_slave_addr (req_slave_addr),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_distance   (rsp_distance),
      .rsp_frame_len  (rsp_frame_len),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Reflected CRC-16, one byte at a time, LSB first
   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      r = acc ^ {8'h00, data};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   // Verdict on the frame as it stands: length, then CRC, then header
   function automatic reply_fields frame_verdict();
      reply_fields v;
      int got;
      int missing;
      v.status    = ST_OK;
      v.distance  = '0;
      v.frame_len = LEN_W'(bytes_in);
      if (bytes_in < MIN_FRAME) begin
         v.status = ST_SHORT;
      end else if (crc_run != {tail_bytes[1], tail_bytes[0]}) begin
         v.status = ST_CRC;
      end else if (!header_good) begin
         v.status = ST_HEADER;
      end else begin
         // data bytes asked for but never received count as zero
         got = int'(bytes_in) - 3;
         if (got > int'(data_len)) got = int'(data_len);
         missing = int'(data_len) - got;
         if (missing < 4) v.distance = data_acc << (8 * missing);
      end
      return v;
   endfunction

   task automatic clear_frame_state();
      crc_run       = CRC_INIT;
      tail_bytes[0] = 8'h00;
      tail_bytes[1] = 8'h00;
      bytes_in      = 0;
      header_good   = 1'b1;
      data_len      = 8'h00;
      data_acc      = '0;
      quiet_ticks   = '0;
      waited_ticks  = '0;
   endtask

   // Advance the tracker by one accepted request; queue any reply it causes
   task automatic track_request(input logic [1:0] cmd, input logic [7:0] addr,
                                input logic [7:0] data);
      logic        gap_end;
      logic        time_end;
      reply_fields late;
      if (cmd == CMD_START) begin
         live_requests++;
         frame_open = 1'b1;
         armed_addr = addr;
         clear_frame_state();
      end else if (frame_open && cmd == CMD_BYTE) begin
         live_requests++;
         if (bytes_in < FRAME_BYTES) begin
            if (bytes_in == 0 && data != armed_addr) header_good = 1'b0;
            if (bytes_in == 1 && data != FUNC_READ) header_good = 1'b0;
            if (bytes_in == 2) data_len = data;
            if (bytes_in >= 3 && (bytes_in - 3) < data_len) data_acc = {data_acc[23:0], data};
            // the newest two bytes stay out of the CRC until more arrive
            if (bytes_in >= 2) crc_run = crc16_step(crc_run, tail_bytes[0]);
            tail_bytes[0] = tail_bytes[1];
            tail_bytes[1] = data;
            bytes_in++;
            quiet_ticks = '0;
            if (bytes_in >= FRAME_BYTES) begin
               awaited_replies.push_back(frame_verdict());
               frame_open = 1'b0;
            end
         end
      end else if (frame_open && cmd == CMD_TICK) begin
         live_requests++;
         gap_end  = (bytes_in > 0) && (quiet_ticks >= gap_limit);
         time_end = ({1'b0, waited_ticks} + 33'd1) >= {1'b0, timeout_limit};
         if (quiet_ticks != 16'hFFFF) quiet_ticks++;
         if (waited_ticks != 32'hFFFF_FFFF) waited_ticks++;
         // the silence gap takes precedence over the timeout on the same tick
         if (gap_end) begin
            awaited_replies.push_back(frame_verdict());
            frame_open = 1'b0;
         end else if (time_end) begin
            late.status    = ST_TIMEOUT;
            late.distance  = '0;
            late.frame_len = LEN_W'(bytes_in);
            awaited_replies.push_back(late);
            frame_open = 1'b0;
         end
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP) $display("ERROR @%0t: %s", $time, what);
   endtask

   // Present one request and hold it until the checker takes it
   task automatic send_request(input logic [1:0] cmd, input logic [7:0] addr,
                               input logic [7:0] data);
      int pause;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         pause = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_slave_addr <= addr;
      req_rx_byte    <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_request(cmd, addr, data);
   endtask

   // Unused fields carry random junk so that every bit toggles
   task automatic send_start(input logic [7:0] addr);
      send_request(CMD_START, addr, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_request(CMD_BYTE, 8'($urandom), data);
   endtask

   task automatic send_tick();
      send_request(CMD_TICK, 8'($urandom), 8'($urandom));
   endtask

   // Tick until the open frame yields its reply, giving up after cap ticks
   task automatic tick_until_reply(input int cap);
      int n;
      n = 0;
      while (frame_open && n < cap) begin
         send_tick();
         n++;
      end
   endtask

   // Build addr, function, byte count, data and a CRC that matches them
   task automatic compose_frame(input logic [7:0] addr, input logic [7:0] func,
                                input logic [7:0] count, input int ndata, input int fill);
      logic [15:0] c;
      frame_bytes.delete();
      frame_bytes.push_back(addr);
      frame_bytes.push_back(func);
      frame_bytes.push_back(count);
      repeat (ndata) frame_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      c = CRC_INIT;
      foreach (frame_bytes[i]) c = crc16_step(c, frame_bytes[i]);
      frame_bytes.push_back(c[7:0]);
      frame_bytes.push_back(c[15:8]);
   endtask

   // Put the frame on the line; spaced frames get silent ticks between bytes
   task automatic feed_frame(input bit spaced);
      int hi;
      int quiet;
      foreach (frame_bytes[i]) begin
         send_byte(frame_bytes[i]);
         quiet = 0;
         if (spaced) begin
            hi = (gap_limit > 4) ? 4 : int'(gap_limit);
            case ($urandom_range(0, 19))
               0, 1, 2, 3: if (hi > 0) quiet = $urandom_range(1, hi);
               4:          if (gap_limit < 8) quiet = int'(gap_limit) + 1; // split the frame
               default:    quiet = 0;
            endcase
         end
         repeat (quiet) send_tick();
      end
   endtask

   // Hold off new requests until every reply is in and the pipeline is empty
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Drive one write for a cycle; the caller drops the write enable afterwards
   task automatic write_setting(input logic index, input logic [31:0] value);
      csr_index   <= index;
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      if (index == CSR_GAP_TICKS) gap_limit = value[15:0];
      else                        timeout_limit = value;
   endtask

   task automatic apply_settings(input logic [15:0] gap, input logic [31:0] timeout);
      drain_replies();
      write_setting(CSR_GAP_TICKS, {16'h0000, gap});
      write_setting(CSR_TIMEOUT_TICKS, timeout);
      csr_wr_en <= 1'b0;
   endtask

   // Reset values: a valid frame must close only after 305 silent ticks
   task automatic check_reset_gap();
      send_start(8'h11);
      compose_frame(8'h11, FUNC_READ, 8'd2, 2, -1);
      feed_frame(1'b0);
      tick_until_reply(400);
   endtask

   // Bytes, ticks and the spare command with nothing armed: no reply at all
   task automatic check_ignored_requests();
      apply_settings(16'd0, 32'hFFFF_FFFF);
      send_byte(8'h00);
      send_tick();
      send_request(CMD_SPARE, 8'hFF, 8'hFF);
   endtask

   // Start while busy drops the partial frame; spare command mid-frame changes nothing
   task automatic check_restart();
      send_start(8'h00);
      send_byte(8'h00);
      send_request(CMD_SPARE, 8'h00, 8'h00);
      send_start(8'h5A);
      send_tick();
      compose_frame(8'h5A, FUNC_READ, 8'd1, 1, -1);
      feed_frame(1'b0);
      send_tick();
   endtask

   // Byte count beyond the frame: CRC bytes get taken in, the rest reads as zero
   task automatic check_data_past_frame();
      send_start(8'hFF);
      compose_frame(8'hFF, FUNC_READ, 8'd6, 2, 8'hFF);
      feed_frame(1'b0);
      send_tick();
      send_start(8'h00);
      compose_frame(8'h00, FUNC_READ, 8'd4, 4, 8'hFF);
      feed_frame(1'b0);
      send_tick();
   endtask

   // Gap wins over timeout on the same tick; timeout alone with nothing received
   task automatic check_tick_order();
      apply_settings(16'd0, 32'd1);
      send_start(8'h00);
      send_byte(8'h00);
      send_tick();
      send_start(8'h00);
      send_tick();
   endtask

   // The sixteenth byte closes the frame on the spot; the next byte is dropped
   task automatic check_full_buffer();
      apply_settings(16'd0, 32'hFFFF_FFFF);
      send_start(8'h00);
      compose_frame(8'h00, FUNC_READ, 8'd11, 11, -1);
      feed_frame(1'b0);
      send_byte(8'hFF);
   endtask

   // One random exchange: mostly well-formed replies, the rest damaged or noise
   task automatic random_exchange();
      logic [7:0] addr;
      logic [7:0] func;
      int kind;
      int count;
      int ndata;
      int idx;
      int keep;
      int cap;
      if ($urandom_range(0, 9) == 0)
         send_request(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom));
      addr  = 8'($urandom);
      kind  = $urandom_range(0, 99);
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 11);
      ndata = (count > 13) ? 13 : count;
      if (kind < 10) ndata = $urandom_range(0, ndata);
      send_start(addr);
      if (kind >= 10 && kind < 18) begin
         compose_frame(addr ^ 8'($urandom_range(1, 255)), FUNC_READ, 8'(count), ndata, -1);
      end else if (kind >= 18 && kind < 26) begin
         func = 8'($urandom);
         if (func == FUNC_READ) func = func ^ 8'h80;
         compose_frame(addr, func, 8'(count), ndata, -1);
      end else begin
         compose_frame(addr, FUNC_READ, 8'(count), ndata, -1);
      end
      if (kind >= 26 && kind < 34) begin
         idx = $urandom_range(0, frame_bytes.size() - 1);
         frame_bytes[idx] = frame_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
      end else if (kind >= 34 && kind < 40) begin
         keep = $urandom_range(0, 4);
         while (frame_bytes.size() > keep) frame_bytes.delete(frame_bytes.size() - 1);
      end else if (kind >= 40 && kind < 45) begin
         frame_bytes.delete();
         repeat ($urandom_range(1, 18)) frame_bytes.push_back(8'($urandom));
      end else if (kind >= 45 && kind < 50) begin
         // abandon a partial frame and re-arm
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         send_start(addr);
      end
      feed_frame(1'b1);
      cap = (gap_limit < 60) ? int'(gap_limit) + 2 : 60;
      tick_until_reply(cap);
   endtask

   // Phases of random traffic, each under its own gap and timeout settings
   task automatic check_random_traffic();
      int first;
      int phase_first;
      int phase_no;
      logic [15:0] gap;
      logic [31:0] timeout;
      first    = live_requests;
      phase_no = 0;
      while (live_requests - first < RANDOM_REQUESTS) begin
         case (phase_no)
            0: begin gap = 16'd0;      timeout = 32'hFFFF_FFFF; end
            1: begin gap = 16'hFFFF;   timeout = 32'd40;        end
            2: begin gap = 16'd3;      timeout = 32'd0;         end
            3: begin gap = 16'd1;      timeout = 32'd1;         end
            default: begin
               gap     = 16'($urandom_range(0, 8));
               timeout = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(8, 90));
            end
         endcase
         apply_settings(gap, timeout);
         phase_first = live_requests;
         while (live_requests - phase_first < PHASE_REQUESTS &&
                live_requests - first < RANDOM_REQUESTS) begin
            // run the tail of the traffic flat out on both sides
            if (live_requests - first >= CALM_FROM) idling_on = 1'b0;
            random_exchange();
         end
         phase_no++;
      end
   endtask

   // Random back-pressure on the reply side, in bursts
   always @(posedge clock) begin
      if (reset || !idling_on) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each reply taken from the checker against the oldest prediction
   always @(posedge clock) begin : check_replies
      reply_fields want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            report_mismatch($sformatf("reply with none pending: status %0d len %0d",
                                      rsp_status, rsp_frame_len));
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_status != want.status)
               report_mismatch($sformatf("status %0d, predicted %0d",
                                         rsp_status, want.status));
            if (rsp_distance != want.distance)
               report_mismatch($sformatf("distance %08h, predicted %08h",
                                         rsp_distance, want.distance));
            if (rsp_frame_len != want.frame_len)
               report_mismatch($sformatf("frame_len %0d, predicted %0d",
                                         rsp_frame_len, want.frame_len));
         end
      end
   end

   initial begin
      int spare;
      // model state after reset
      frame_open    = 1'b0;
      armed_addr    = 8'h00;
      gap_limit     = GAP_RESET;
      timeout_limit = TIMEOUT_RESET;
      clear_frame_state();
      repeat (11) @(posedge clock);
      reset     <= 1'b0;
      idling_on = 1'b1;

      check_reset_gap();
      check_ignored_requests();
      check_restart();
      check_data_past_frame();
      check_tick_order();
      check_full_buffer();
      check_random_traffic();

      // drain what is still in flight, then allow for the pipeline latency
      req_valid <= 1'b0;
      spare = 0;
      while (awaited_replies.size() != 0 && spare < 20000) begin
         @(posedge clock);
         spare++;
      end
      repeat (8) @(posedge clock);
      if (awaited_replies.size() != 0)
         report_mismatch($sformatf("%0d predicted replies never arrived",
                                   awaited_replies.size()));
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ modbus_rtu_reply_checker.f @@
+incdir+rtl/core
rtl/core/mrrc_pkg.sv
rtl/core/mrrc_frame.sv
rtl/core/mrrc_rsp_reg.sv
rtl/core/modbus_rtu_reply_checker.sv
rtl/core/mrrc_checker.sv
tb/sv/tb_modbus_rtu_reply_checker.sv
